### src/gbs_pkg.sv
// Shared constants, payload structs and register codes of the background subtractor.
// No dependencies; the files that use it refer to it by scoped names.
package gbs_pkg;

   localparam int PIXELS    = 65536;
   localparam int CHANNELS  = 3;
   localparam int FIELD_CH  = 3;
   localparam int ADDR_W    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int RNG_W     = 23;
   localparam int IDX_W     = 16;
   localparam int FRAME_W   = 32;
   localparam int MEAN_W    = 16;
   localparam int VAR_W     = 24;
   localparam int PERIOD_W  = 16;
   localparam int GAIN_W    = 8;
   localparam int RATE_W    = 16;
   localparam int ENTRY_W   = CHANNELS * (MEAN_W + VAR_W);
   localparam int DIV_STEPS = FRAME_W;
   localparam int REQ_W     = 168;
   localparam int RSP_W     = 24;

   typedef enum logic [1:0] {
      CSR_GAIN  = 2'd0,
      CSR_RATE  = 2'd1,
      CSR_SHORT = 2'd2,
      CSR_LONG  = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic                              req_type;
      logic [IDX_W-1:0]                  idx;
      logic [FRAME_W-1:0]                frame;
      logic [FIELD_CH-1:0][MEAN_W-1:0]   val;
      logic [FIELD_CH-1:0][VAR_W-1:0]    var_ld;
   } item_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   gain;
      logic [RATE_W-1:0]   rate;
      logic [PERIOD_W-1:0] short_p;
      logic [PERIOD_W-1:0] long_p;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  idx;
      logic              fg;
      logic              upd;
   } res_type;

endpackage

### src/gbs_period_pipe.sv
// Pipelined remainder test of the frame number against both update periods.
// Depends on gbs_pkg.
module gbs_period_pipe (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  gbs_pkg::item_type                in_item,
   input  logic [gbs_pkg::PERIOD_W-1:0]     short_p,
   input  logic [gbs_pkg::PERIOD_W-1:0]     long_p,
   output logic                             out_valid,
   output gbs_pkg::item_type                out_item,
   output logic                             short_hit,
   output logic                             long_hit
);

   function automatic logic [gbs_pkg::PERIOD_W-1:0] rem_step(
      input logic [gbs_pkg::PERIOD_W-1:0] rem,
      input logic                         nbit,
      input logic [gbs_pkg::PERIOD_W-1:0] p);
      logic [gbs_pkg::PERIOD_W:0] r2;
      r2 = {rem, nbit};
      if (r2 >= {1'b0, p}) begin
         r2 = r2 - {1'b0, p};
      end
      return r2[gbs_pkg::PERIOD_W-1:0];
   endfunction

   logic                          valid_ff [gbs_pkg::DIV_STEPS+1];
   gbs_pkg::item_type             item_ff  [gbs_pkg::DIV_STEPS+1];
   logic [gbs_pkg::PERIOD_W-1:0]  rs_ff    [gbs_pkg::DIV_STEPS+1];
   logic [gbs_pkg::PERIOD_W-1:0]  rl_ff    [gbs_pkg::DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         item_ff[0] <= in_item;
         rs_ff[0]   <= '0;
         rl_ff[0]   <= '0;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < gbs_pkg::DIV_STEPS; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (en) begin
            item_ff[k+1] <= item_ff[k];
            rs_ff[k+1]   <= rem_step(rs_ff[k], item_ff[k].frame[gbs_pkg::FRAME_W-1-k], short_p);
            rl_ff[k+1]   <= rem_step(rl_ff[k], item_ff[k].frame[gbs_pkg::FRAME_W-1-k], long_p);
         end
      end
   end

   assign out_valid = valid_ff[gbs_pkg::DIV_STEPS];
   assign out_item  = item_ff[gbs_pkg::DIV_STEPS];
   assign short_hit = (short_p != '0) && (rs_ff[gbs_pkg::DIV_STEPS] == '0);
   assign long_hit  = (long_p != '0) && (rl_ff[gbs_pkg::DIV_STEPS] == '0);

endmodule

### src/gbs_model_datapath.sv
// Model memory with its read-modify-write pipeline: detection, running average, write-back.
// Depends on gbs_pkg.
module gbs_model_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 r_valid,
   input  gbs_pkg::item_type    r_item,
   input  logic                 r_short,
   input  logic                 r_long,
   input  gbs_pkg::cfg_type     cfg,
   output logic                 hazard,
   output gbs_pkg::res_type     res
);

   localparam int CH = gbs_pkg::CHANNELS;
   localparam int MW = gbs_pkg::MEAN_W;
   localparam int VW = gbs_pkg::VAR_W;

   logic [gbs_pkg::ENTRY_W-1:0] mem [gbs_pkg::PIXELS];
   logic [gbs_pkg::ENTRY_W-1:0] rdata_ff;

   // R stage decode
   logic [gbs_pkg::ADDR_W-1:0]  r_addr;
   logic                        r_rng;
   logic [gbs_pkg::ENTRY_W-1:0] r_ld;
   logic [CH-1:0][7:0]          r_pix;
   logic                        r_take;

   assign r_addr = gbs_pkg::ADDR_W'(r_item.idx);
   assign r_rng  = gbs_pkg::RNG_W'(r_item.idx) < gbs_pkg::RNG_W'(gbs_pkg::PIXELS);

   for (genvar c = 0; c < CH; c++) begin : g_dec
      if (c < gbs_pkg::FIELD_CH) begin : g_fld
         assign r_pix[c]             = r_item.val[c][7:0];
         assign r_ld[c*MW +: MW]     = r_item.val[c];
         assign r_ld[CH*MW + c*VW +: VW] = r_item.var_ld[c];
      end else begin : g_zero
         assign r_pix[c]             = '0;
         assign r_ld[c*MW +: MW]     = '0;
         assign r_ld[CH*MW + c*VW +: VW] = '0;
      end
   end

   // stage valids and shared control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [gbs_pkg::IDX_W-1:0] i1_ff, i2_ff, i3_ff, i4_ff, i5_ff;
   logic ld1_ff, ld2_ff, ld3_ff, ld4_ff, ld5_ff;
   logic rg1_ff, rg2_ff, rg3_ff, rg4_ff, rg5_ff;
   logic sh1_ff, sh2_ff, sh3_ff;
   logic lg1_ff, lg2_ff, lg3_ff;
   logic [gbs_pkg::ENTRY_W-1:0] e1_ff, e2_ff, e3_ff, e4_ff, e5_ff;
   logic [CH-1:0][7:0] p1_ff;

   // hold the read while an older beat for the same pixel is still in flight
   assign hazard = r_valid && ((v1_ff && i1_ff == r_item.idx) || (v2_ff && i2_ff == r_item.idx) ||
                               (v3_ff && i3_ff == r_item.idx) || (v4_ff && i4_ff == r_item.idx) ||
                               (v5_ff && i5_ff == r_item.idx));
   assign r_take = adv && !hazard;

   // S1 datapath: deviation from stored mean
   logic [CH-1:0][MW-1:0] m1, x1, d1;
   logic [CH-1:0][VW-1:0] v1;
   always_comb begin
      for (int c = 0; c < CH; c++) begin
         m1[c] = rdata_ff[c*MW +: MW];
         v1[c] = rdata_ff[CH*MW + c*VW +: VW];
         x1[c] = {p1_ff[c], 8'h00};
         d1[c] = (x1[c] >= m1[c]) ? (x1[c] - m1[c]) : (m1[c] - x1[c]);
      end
   end

   logic [CH-1:0][MW-1:0] m2_ff, x2_ff, d2_ff;
   logic [CH-1:0][VW-1:0] vv2_ff;

   // S3 products
   logic [15:0]                  g2_ff;
   logic [gbs_pkg::RATE_W:0]     na;
   logic [CH-1:0][31:0]          dd3_ff;
   logic [CH-1:0][39:0]          gv3_ff;
   logic [CH-1:0][32:0]          mna3_ff;
   logic [CH-1:0][31:0]          xa3_ff;
   logic [CH-1:0][40:0]          vna3_ff;
   assign na = 17'h10000 - {1'b0, cfg.rate};

   // S4: decision, mean blend, deviation weight
   logic                 fg_any;
   logic [CH-1:0][33:0]  msum;
   logic                 fg4_ff, upd4_ff;
   logic [CH-1:0][47:0]  d2a4_ff;
   logic [CH-1:0][MW-1:0] nm4_ff;
   logic [CH-1:0][40:0]  vna4_ff;
   always_comb begin
      fg_any = 1'b0;
      for (int c = 0; c < CH; c++) begin
         if ({8'h00, dd3_ff[c]} >= gv3_ff[c]) begin
            fg_any = 1'b1;
         end
         msum[c] = 34'(mna3_ff[c]) + 34'(xa3_ff[c]) + 34'd32768;
      end
   end

   // S5: variance blend, registered with the decision, then write-back
   logic [CH-1:0][49:0]  vsum;
   logic [gbs_pkg::ENTRY_W-1:0] wcalc, wd5_ff, wdata;
   logic                 fg5_ff, upd5_ff;
   logic                 we;
   always_comb begin
      for (int c = 0; c < CH; c++) begin
         vsum[c] = 50'({vna4_ff[c], 8'h00}) + 50'(d2a4_ff[c]) + 50'h800000;
         wcalc[c*MW +: MW]         = nm4_ff[c];
         wcalc[CH*MW + c*VW +: VW] = vsum[c][47:24];
      end
   end
   assign wdata = ld5_ff ? e5_ff : wd5_ff;
   assign we = adv && v5_ff && rg5_ff && (ld5_ff || upd5_ff);

   always_ff @(posedge clock) begin
      if (r_take && r_valid) begin
         rdata_ff <= mem[r_addr];
      end
      if (we) begin
         mem[gbs_pkg::ADDR_W'(i5_ff)] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= r_valid && !hazard;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      g2_ff <= 16'(cfg.gain * cfg.gain);
      if (adv) begin
         i1_ff <= r_item.idx;  i2_ff <= i1_ff;  i3_ff <= i2_ff;  i4_ff <= i3_ff;  i5_ff <= i4_ff;
         ld1_ff <= r_item.req_type;  ld2_ff <= ld1_ff;  ld3_ff <= ld2_ff;
         ld4_ff <= ld3_ff;  ld5_ff <= ld4_ff;
         rg1_ff <= r_rng;  rg2_ff <= rg1_ff;  rg3_ff <= rg2_ff;  rg4_ff <= rg3_ff;  rg5_ff <= rg4_ff;
         sh1_ff <= r_short;  sh2_ff <= sh1_ff;  sh3_ff <= sh2_ff;
         lg1_ff <= r_long;   lg2_ff <= lg1_ff;  lg3_ff <= lg2_ff;
         e1_ff <= r_ld;  e2_ff <= e1_ff;  e3_ff <= e2_ff;  e4_ff <= e3_ff;  e5_ff <= e4_ff;
         p1_ff <= r_pix;
         m2_ff  <= m1;
         x2_ff  <= x1;
         d2_ff  <= d1;
         vv2_ff <= v1;
         for (int c = 0; c < CH; c++) begin
            dd3_ff[c]  <= d2_ff[c] * d2_ff[c];
            gv3_ff[c]  <= g2_ff * vv2_ff[c];
            mna3_ff[c] <= m2_ff[c] * na;
            xa3_ff[c]  <= x2_ff[c] * cfg.rate;
            vna3_ff[c] <= vv2_ff[c] * na;
            d2a4_ff[c] <= dd3_ff[c] * cfg.rate;
            nm4_ff[c]  <= msum[c][31:16];
            vna4_ff[c] <= vna3_ff[c];
         end
         fg4_ff  <= fg_any && rg3_ff && !ld3_ff;
         // short-period test wins; long period applies only when short is not met
         upd4_ff <= rg3_ff && !ld3_ff && ((sh3_ff && !fg_any) || (!sh3_ff && lg3_ff));
         wd5_ff  <= wcalc;
         fg5_ff  <= fg4_ff;
         upd5_ff <= upd4_ff;
      end
   end

   assign res.valid = v5_ff;
   assign res.idx   = i5_ff;
   assign res.fg    = fg5_ff;
   assign res.upd   = upd5_ff;

endmodule

### src/gaussian_background_subtractor_core.sv
// Top level of the per-pixel Gaussian background subtractor: ports, registers, output skid.
// Depends on gbs_pkg, gbs_period_pipe and gbs_model_datapath.
//
// Usage:
//   req_* carries one beat per pixel. tuser selects the kind: 0 processes a pixel
//   (low byte of each channel value), 1 loads that pixel's mean and variance.
//   rsp_* returns one beat per request beat, in order: echoed index, foreground flag
//   and whether the running average was applied (both 0 for a load).
//   csr_* writes deviation_gain, learning_rate, short_period and long_period; write
//   them only while no beat is in flight.
// Path: an accepted request beat enters an input register and a 32-stage remainder
//   pipeline (one quotient bit a stage) for both period tests, then a five-stage
//   read-modify-write pipeline around the model memory, then the output register,
//   which drives rsp_tvalid.
// Throughput: one beat per cycle while no pixel hazard or full skid entry holds the
//   pipeline. A beat whose pixel matches one of the five beats in the memory pipeline
//   waits until that beat has written back.
// Reset clears the pipeline and loads the register defaults; the model memory is
//   not cleared, so load each pixel before it is processed.
// When rsp_tready drops, the output register and one skid entry absorb the beat in
//   flight; the pipeline then holds and req_tready falls.
module gaussian_background_subtractor_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // tdata: pixel_index, frame_number, chan0_value, chan1_value, chan2_value,
   //        chan0_var_load, chan1_var_load, chan2_var_load
   input  logic [gbs_pkg::REQ_W-1:0]  req_tdata,
   // tuser: req_type
   input  logic                       req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // tdata: out_index, foreground, model_updated, zero pad
   output logic [gbs_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [15:0]                csr_wdata
);

   gbs_pkg::cfg_type  cfg_ff;
   gbs_pkg::item_type in_item, r_item;
   gbs_pkg::res_type  res;
   logic              adv, hazard, r_valid, r_short, r_long;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain    <= 8'd40;
         cfg_ff.rate    <= 16'd655;
         cfg_ff.short_p <= 16'd1;
         cfg_ff.long_p  <= 16'd0;
      end else if (csr_we) begin
         case (gbs_pkg::csr_reg_type'(csr_index))
            gbs_pkg::CSR_GAIN:  cfg_ff.gain    <= csr_wdata[7:0];
            gbs_pkg::CSR_RATE:  cfg_ff.rate    <= csr_wdata;
            gbs_pkg::CSR_SHORT: cfg_ff.short_p <= csr_wdata;
            gbs_pkg::CSR_LONG:  cfg_ff.long_p  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // unpack the request beat
   assign in_item.req_type  = req_tuser;
   assign in_item.idx       = req_tdata[15:0];
   assign in_item.frame     = req_tdata[47:16];
   assign in_item.val[0]    = req_tdata[63:48];
   assign in_item.val[1]    = req_tdata[79:64];
   assign in_item.val[2]    = req_tdata[95:80];
   assign in_item.var_ld[0] = req_tdata[119:96];
   assign in_item.var_ld[1] = req_tdata[143:120];
   assign in_item.var_ld[2] = req_tdata[167:144];

   assign req_tready = adv && !hazard;

   gbs_period_pipe u_period (
      .clock     (clock),
      .reset     (reset),
      .en        (req_tready),
      .in_valid  (req_tvalid),
      .in_item   (in_item),
      .short_p   (cfg_ff.short_p),
      .long_p    (cfg_ff.long_p),
      .out_valid (r_valid),
      .out_item  (r_item),
      .short_hit (r_short),
      .long_hit  (r_long)
   );

   gbs_model_datapath u_model (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .r_valid (r_valid),
      .r_item  (r_item),
      .r_short (r_short),
      .r_long  (r_long),
      .cfg     (cfg_ff),
      .hazard  (hazard),
      .res     (res)
   );

   // output register plus one skid entry
   logic              out_v_ff, skid_v_ff;
   gbs_pkg::res_type  out_ff, skid_ff;
   logic              take;

   assign adv  = !skid_v_ff;
   assign take = res.valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= take;
         end
      end else if (take) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         out_ff <= skid_v_ff ? skid_ff : res;
      end else if (take) begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {6'd0, out_ff.upd, out_ff.fg, out_ff.idx};

endmodule

### src/gbs_checker.sv
// Port-level checks on the background subtractor's result channel.
// Depends on gaussian_background_subtractor_core, to which it is bound below.
module gbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp data changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp beat right after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:18] == 6'd0)
      else $error("rsp pad bits set");

endmodule

bind gaussian_background_subtractor_core gbs_checker u_gbs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/testbench.sv
// Self-checking testbench for gaussian_background_subtractor_core.
// Depends on gbs_pkg and the core; drives request beats, predicts and checks each response.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [gbs_pkg::REQ_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [gbs_pkg::RSP_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   localparam int LATENCY = 39;
   localparam int NPIX = 16;   // pixels used by random traffic, kept loaded

   always #1 clock = ~clock;

   gaussian_background_subtractor_core uut (.*);

   typedef struct packed {
      logic [15:0] idx;
      logic        fg;
      logic        upd;
   } verdict_type;

   // Predictor state: model of each pixel and register copies.
   logic [gbs_pkg::MEAN_W-1:0] model_mean [int];
   logic [gbs_pkg::VAR_W-1:0]  model_var  [int];
   logic [7:0]  gain_q = 8'd40;
   logic [15:0] rate_q = 16'd655;
   logic [15:0] short_q = 16'd1;
   logic [15:0] long_q = 16'd0;

   verdict_type pending_verdicts[$];
   int errors = 0;
   bit rsp_idle_ok = 1'b1;

   // Compute the expected verdict and advance the model for one request.
   function automatic verdict_type predict_pixel(input logic kind, input logic [15:0] idx,
                                                 input logic [31:0] frame,
                                                 input logic [2:0][15:0] val,
                                                 input logic [2:0][23:0] vld);
      verdict_type r;
      logic [63:0] g2, a, na, x, m, v, d;
      bit do_s, do_l;
      int e;
      r.idx = idx; r.fg = 1'b0; r.upd = 1'b0;
      if (kind) begin
         for (int c = 0; c < gbs_pkg::CHANNELS; c++) begin
            e = idx * gbs_pkg::CHANNELS + c;
            model_mean[e] = val[c];
            model_var[e] = vld[c];
         end
         return r;
      end
      g2 = gain_q * gain_q;
      a = rate_q;
      na = 64'd65536 - a;
      for (int c = 0; c < gbs_pkg::CHANNELS; c++) begin
         e = idx * gbs_pkg::CHANNELS + c;
         x = {val[c][7:0], 8'h00};
         m = model_mean.exists(e) ? model_mean[e] : 0;
         v = model_var.exists(e) ? model_var[e] : 0;
         d = x >= m ? x - m : m - x;
         if (d * d >= g2 * v) r.fg = 1'b1;
      end
      do_s = short_q != 0 && (frame % short_q) == 0;
      do_l = !do_s && long_q != 0 && (frame % long_q) == 0;
      r.upd = (do_s && !r.fg) || do_l;
      if (r.upd) begin
         for (int c = 0; c < gbs_pkg::CHANNELS; c++) begin
            e = idx * gbs_pkg::CHANNELS + c;
            x = {val[c][7:0], 8'h00};
            m = model_mean.exists(e) ? model_mean[e] : 0;
            v = model_var.exists(e) ? model_var[e] : 0;
            d = x >= m ? x - m : m - x;
            model_mean[e] = 16'((m * na + x * a + 64'd32768) >> 16);
            model_var[e] = 24'((v * na * 256 + d * d * a + 64'd8388608) >> 24);
         end
      end
      return r;
   endfunction

   // Drop tvalid and idle for a random number of cycles, or not at all.
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) n = 0;
      if (n != 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Send one request beat and record its expected response; tvalid stays high on return.
   task automatic send_pixel(input logic kind, input logic [15:0] idx, input logic [31:0] frame,
                             input logic [2:0][15:0] val, input logic [2:0][23:0] vld,
                             input bit gaps = 1'b1);
      if (gaps) idle_gap();
      pending_verdicts.push_back(predict_pixel(kind, idx, frame, val, vld));
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      // fields from the low bits up: index, frame, values, variances
      req_tdata  <= {vld[2], vld[1], vld[0], val[2], val[1], val[0], frame, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold until all responses are back, then let the pipeline drain.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_csr(input gbs_pkg::csr_reg_type which, input logic [15:0] data);
      drain();
      csr_we <= 1'b1; csr_index <= which; csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (which)
         gbs_pkg::CSR_GAIN:  gain_q = data[7:0];
         gbs_pkg::CSR_RATE:  rate_q = data;
         gbs_pkg::CSR_SHORT: short_q = data;
         gbs_pkg::CSR_LONG:  long_q = data;
         default: ;
      endcase
   endtask

   // Response checker: compare each accepted beat with the oldest prediction.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected response beat, actual %h", $realtime, rsp_tdata);
            errors++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata[15:0] !== want.idx) begin
               $display("%0t: index expected %h actual %h", $realtime, want.idx,
                        rsp_tdata[15:0]);
               errors++;
            end
            if (rsp_tdata[16] !== want.fg) begin
               $display("%0t: foreground expected %b actual %b (idx %h)", $realtime,
                        want.fg, rsp_tdata[16], want.idx);
               errors++;
            end
            if (rsp_tdata[17] !== want.upd) begin
               $display("%0t: updated expected %b actual %b (idx %h)", $realtime,
                        want.upd, rsp_tdata[17], want.idx);
               errors++;
            end
         end
      end
   end

   // Randomly stall the response side, with quiet stretches when disabled.
   always @(posedge clock) begin
      if (!rsp_idle_ok) rsp_tready <= 1'b1;
      else if ($urandom_range(0, 19) == 0) rsp_tready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) rsp_tready <= 1'b1;
      else if (rsp_tready == 1'b0 && $urandom_range(0, 9) == 0) rsp_tready <= 1'b1;
   end

   function automatic logic [2:0][15:0] rand_vals();
      logic [2:0][15:0] v;
      for (int c = 0; c < 3; c++) v[c] = 16'($urandom);
      return v;
   endfunction

   function automatic logic [2:0][23:0] rand_vars();
      logic [2:0][23:0] v;
      for (int c = 0; c < 3; c++)
         v[c] = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4096));
      return v;
   endfunction

   // Load every pixel of the random pool so no unwritten entry is ever read.
   task automatic test_load_pool();
      for (int p = 0; p < NPIX; p++)
         send_pixel(1'b1, 16'(p), $urandom, rand_vals(), rand_vars());
   endtask

   // Directed: field extremes, both kinds, upper pixel bits, far indexes.
   task automatic test_directed();
      logic [2:0][15:0] ones16 = {3{16'hFFFF}};
      logic [2:0][23:0] ones24 = {3{24'hFFFFFF}};
      send_pixel(1'b1, 16'hFFFF, 32'hFFFFFFFF, ones16, ones24);
      send_pixel(1'b0, 16'hFFFF, 32'hFFFFFFFF, ones16, ones24);
      send_pixel(1'b1, 16'h8000, 32'd0, '0, '0);
      send_pixel(1'b0, 16'h8000, 32'd0, '0, '0);         // zero variance, d = 0: foreground
      send_pixel(1'b0, 16'h8000, 32'd0, {3{16'hFF00}}, ones24);   // upper bits ignored
      send_pixel(1'b1, 16'h0000, 32'd5, {3{16'h8000}}, {3{24'h000100}});
      send_pixel(1'b0, 16'h0000, 32'd0, {3{16'h0080}}, '0);  // background, updated
      send_pixel(1'b0, 16'h0000, 32'd1, {3{16'h00FF}}, ones24);
      send_pixel(1'b0, 16'h0000, 32'd7, {3{16'h0000}}, '0);
      send_pixel(1'b1, 16'h0001, 32'h55555555, {16'h0102, 16'h7FFF, 16'hAAAA},
                 {24'h123456, 24'hAAAAAA, 24'h555555});
      // back-to-back repeats of one pixel
      for (int i = 0; i < 4; i++)
         send_pixel(1'b0, 16'h0001, i, rand_vals(), rand_vars(), 1'b0);
   endtask

   // Random traffic under one register setting.
   task automatic test_random(input int count);
      logic [15:0] idx;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            idx = 16'($urandom_range(0, NPIX - 1));
            send_pixel(1'b1, idx, $urandom, rand_vals(), rand_vars(), 1'($urandom_range(0, 1)));
         end else begin
            idx = 16'($urandom_range(0, NPIX - 1));
            send_pixel(1'b0, idx, ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 20)),
                       rand_vals(), rand_vars(), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Sender pauses until every response is back, then resumes.
   task automatic test_pause();
      test_random(20);
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      test_random(20);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_load_pool();
      test_random(150);
      write_csr(gbs_pkg::CSR_GAIN, 16'd0);
      write_csr(gbs_pkg::CSR_RATE, 16'd65535);
      write_csr(gbs_pkg::CSR_SHORT, 16'd0);
      write_csr(gbs_pkg::CSR_LONG, 16'd3);
      test_random(100);
      write_csr(gbs_pkg::CSR_GAIN, 16'd255);
      write_csr(gbs_pkg::CSR_RATE, 16'd0);
      write_csr(gbs_pkg::CSR_SHORT, 16'd2);
      write_csr(gbs_pkg::CSR_LONG, 16'd1);
      test_random(100);
      write_csr(gbs_pkg::CSR_GAIN, 16'd8);
      write_csr(gbs_pkg::CSR_RATE, 16'd30000);
      write_csr(gbs_pkg::CSR_SHORT, 16'd65535);
      write_csr(gbs_pkg::CSR_LONG, 16'd65535);
      test_pause();
      rsp_idle_ok = 1'b0;
      test_random(60);
      rsp_idle_ok = 1'b1;
      write_csr(gbs_pkg::CSR_GAIN, 16'd24);
      write_csr(gbs_pkg::CSR_RATE, 16'd4000);
      write_csr(gbs_pkg::CSR_SHORT, 16'd1);
      write_csr(gbs_pkg::CSR_LONG, 16'd0);
      test_random(260);
      drain();
      if (errors == 0) $display("[gaussian_background_subtractor_core] OK");
      else $display("[gaussian_background_subtractor_core] ERROR");
      $finish;
   end

   initial begin
      #400000;
      $display("[gaussian_background_subtractor_core] ERROR");
      $finish;
   end
endmodule
